// ----- rtl/bll_pkg.sv -----
// Shared types, constants and character helpers for the BASIC line lexer.
package bll_pkg;

  localparam int unsigned MAX_LINE      = 255;
  localparam int unsigned KEYWORD_CHARS = 6;
  localparam int unsigned KW_IDX_W      = $clog2(KEYWORD_CHARS);
  localparam int unsigned KW_NUM        = 36;
  localparam int unsigned KW_TEXT_CHARS = 6;
  localparam int unsigned OUTQ_DEPTH    = 4;
  localparam int unsigned OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] LEN_MAX   = 8'hFF;

  typedef enum logic [3:0] {
    K_KEYWORD  = 4'd0,
    K_VARIABLE = 4'd1,
    K_NUMBER   = 4'd2,
    K_STRING   = 4'd3,
    K_OPERATOR = 4'd4,
    K_UNARY    = 4'd5,
    K_LE       = 4'd6,
    K_GE       = 4'd7,
    K_END      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    E_OK        = 3'd0,
    E_NUM_ALPHA = 3'd1,
    E_OPEN_STR  = 3'd2,
    E_BAD_CHAR  = 3'd3,
    E_TOO_LONG  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  kw;
    logic [7:0]  op;
    logic [7:0]  start;
    logic [7:0]  len;
    err_e        err;
    logic        last;
  } rec_t;

  // Records produced by one item, in order; cnt is 0 to 2.
  typedef struct packed {
    logic [1:0]      cnt;
    rec_t [1:0]      rec;
  } push_t;

  localparam logic [8*KW_TEXT_CHARS-1:0] KW_STR [KW_NUM] = '{
    "print", "input", "for", "to", "step", "next", "goto", "if", "then",
    "else", "dim", "gosub", "return", "clear", "abs", "and", "atn", "cos",
    "exp", "int", "log", "not", "or", "rnd", "sgn", "sin", "sqr", "tan",
    "len", "chr$", "mid$", "left$", "right$", "asc", "peek", "poke"
  };

  function automatic logic [7:0] kw_len(int unsigned i);
    logic [7:0] n;
    n = '0;
    for (int unsigned j = 0; j < KW_TEXT_CHARS; j++) begin
      if (KW_STR[i][8*j +: 8] != 8'h00) n = n + 8'd1;
    end
    return n;
  endfunction

  // Keyword text with its first character in the top byte.
  function automatic logic [8*KW_TEXT_CHARS-1:0] kw_left(int unsigned i);
    return KW_STR[i] << (8 * (KW_TEXT_CHARS - int'(kw_len(i))));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_numchar(logic [7:0] c);
    return is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic is_wordchar(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_DOLLAR) || (c == CH_PCT);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
  endfunction

  function automatic rec_t mk_rec(kind_e kind, logic [5:0] kw, logic [7:0] op,
                                  logic [7:0] start, logic [7:0] len, err_e err,
                                  logic last);
    rec_t r;
    r.kind  = kind;
    r.kw    = kw;
    r.op    = op;
    r.start = start;
    r.len   = len;
    r.err   = err;
    r.last  = last;
    return r;
  endfunction

endpackage

// ----- rtl/bll_kw_match.sv -----
// Parallel case-folded match of the word buffer against the keyword table.
module bll_kw_match (
  input  logic [bll_pkg::KEYWORD_CHARS-1:0][7:0] wbuf_i,
  input  logic [7:0]                             wlen_i,
  output logic                                   hit_o,
  output logic [5:0]                             idx_o
);
  import bll_pkg::*;

  logic [KW_NUM-1:0]             hit;
  logic [8*KW_TEXT_CHARS-1:0]    kw_txt;

  always_comb begin
    kw_txt = '0;
    for (int unsigned i = 0; i < KW_NUM; i++) begin
      kw_txt = kw_left(i);
      hit[i] = (wlen_i == kw_len(i)) && (wlen_i <= 8'(KEYWORD_CHARS));
      for (int unsigned j = 0; j < KW_TEXT_CHARS; j++) begin
        if ((8'(j) < wlen_i) &&
            (wbuf_i[j] != kw_txt[8*(KW_TEXT_CHARS-j)-1 -: 8])) begin
          hit[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    idx_o = '0;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (hit[i]) idx_o = 6'(i);
    end
  end

  assign hit_o = |hit;

endmodule

// ----- rtl/bll_core.sv -----
// Input register, lexer state and the per-character token step.
module bll_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     ch_i,
  input  logic           end_of_line_i,
  input  logic           room_i,
  output bll_pkg::push_t push_o
);
  import bll_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_NUMBER = 3'd1,
    M_STRING = 3'd2,
    M_WORD   = 3'd3,
    M_PEND   = 3'd4
  } mode_e;

  logic                           in_vld_q;
  logic [7:0]                     ch_q;
  logic                           eol_q;
  logic                           adv;

  mode_e                          mode_q, mode_d;
  logic [7:0]                     pos_q, pos_d;
  logic [7:0]                     start_q, start_d;
  logic [7:0]                     wlen_q, wlen_d;
  logic [KEYWORD_CHARS-1:0][7:0]  wbuf_q, wbuf_d;
  logic                           prev_q, prev_d;
  logic                           disc_q, disc_d;

  logic                           kw_hit;
  logic [5:0]                     kw_idx;
  logic                           close_vld;
  rec_t                           close_rec;
  logic                           close_pv;
  logic                           cb;
  logic [1:0]                     n;
  push_t                          push_d;

  assign adv        = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q  <= ch_i;
      eol_q <= end_of_line_i;
    end
  end

  bll_kw_match u_kw (
    .wbuf_i (wbuf_q),
    .wlen_i (wlen_q),
    .hit_o  (kw_hit),
    .idx_o  (kw_idx)
  );

  // Record for the token in progress, if any.
  always_comb begin
    close_vld = (mode_q == M_NUMBER) || (mode_q == M_WORD) || (mode_q == M_PEND);
    close_pv  = 1'b0;
    case (mode_q)
      M_NUMBER: begin
        close_rec = mk_rec(K_NUMBER, '0, '0, start_q, wlen_q, E_OK, 1'b0);
        close_pv  = 1'b1;
      end
      M_WORD: begin
        if (kw_hit) begin
          close_rec = mk_rec(K_KEYWORD, kw_idx, '0, start_q, wlen_q, E_OK, 1'b0);
        end else begin
          close_rec = mk_rec(K_VARIABLE, '0, '0, start_q, wlen_q, E_OK, 1'b0);
          close_pv  = 1'b1;
        end
      end
      default: begin
        close_rec = mk_rec(K_OPERATOR, '0, wbuf_q[0], start_q, 8'd1, E_OK, 1'b0);
      end
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    wlen_d  = wlen_q;
    wbuf_d  = wbuf_q;
    prev_d  = prev_q;
    disc_d  = disc_q;
    push_d  = '0;
    n       = '0;
    cb      = 1'b0;

    if (adv) begin
      if (eol_q) begin
        if (!disc_q) begin
          if (mode_q == M_STRING) begin
            push_d.rec[0] = mk_rec(K_END, '0, '0, start_q, '0, E_OPEN_STR, 1'b1);
            n = 2'd1;
          end else begin
            if (close_vld) begin
              push_d.rec[0] = close_rec;
              n = 2'd1;
            end
            push_d.rec[n[0]] = mk_rec(K_END, '0, '0, pos_q, '0, E_OK, 1'b1);
            n = n + 2'd1;
          end
        end
        mode_d  = M_IDLE;
        pos_d   = '0;
        start_d = '0;
        wlen_d  = '0;
        prev_d  = 1'b0;
        disc_d  = 1'b0;
      end else if (disc_q) begin
        n = '0;
      end else if (pos_q >= 8'(MAX_LINE)) begin
        push_d.rec[0] = mk_rec(K_END, '0, '0, 8'(MAX_LINE), '0, E_TOO_LONG, 1'b1);
        n      = 2'd1;
        disc_d = 1'b1;
        mode_d = M_IDLE;
      end else begin
        pos_d = pos_q + 8'd1;
        case (mode_q)
          M_STRING: begin
            if (ch_q == CH_QUOTE) begin
              push_d.rec[0] = mk_rec(K_STRING, '0, '0, start_q, wlen_q, E_OK, 1'b0);
              n      = 2'd1;
              prev_d = 1'b0;
              mode_d = M_IDLE;
            end else if (wlen_q != LEN_MAX) begin
              wlen_d = wlen_q + 8'd1;
            end
          end
          M_NUMBER: begin
            if (is_numchar(ch_q)) begin
              if (wlen_q != LEN_MAX) wlen_d = wlen_q + 8'd1;
            end else if (is_alpha(ch_q)) begin
              push_d.rec[0] = mk_rec(K_END, '0, '0, start_q, '0, E_NUM_ALPHA, 1'b1);
              n      = 2'd1;
              disc_d = 1'b1;
              mode_d = M_IDLE;
            end else begin
              cb = 1'b1;
            end
          end
          M_WORD: begin
            if (is_wordchar(ch_q)) begin
              if (wlen_q < 8'(KEYWORD_CHARS)) begin
                wbuf_d[wlen_q[KW_IDX_W-1:0]] = to_lower(ch_q);
              end
              if (wlen_q != LEN_MAX) wlen_d = wlen_q + 8'd1;
            end else begin
              cb = 1'b1;
            end
          end
          M_PEND: begin
            if (ch_q == CH_EQ) begin
              push_d.rec[0] = mk_rec((wbuf_q[0] == CH_LT) ? K_LE : K_GE, '0, '0,
                                     start_q, 8'd2, E_OK, 1'b0);
              n      = 2'd1;
              prev_d = 1'b0;
              mode_d = M_IDLE;
            end else begin
              cb = 1'b1;
            end
          end
          default: cb = 1'b1;
        endcase

        if (cb) begin
          if (close_vld) begin
            push_d.rec[0] = close_rec;
            n      = 2'd1;
            prev_d = close_pv;
          end
          mode_d = M_IDLE;
          if (is_space(ch_q)) begin
            mode_d = M_IDLE;
          end else if (ch_q == CH_QUOTE) begin
            mode_d  = M_STRING;
            start_d = pos_q + 8'd1;
            wlen_d  = '0;
          end else if (is_numchar(ch_q)) begin
            mode_d  = M_NUMBER;
            start_d = pos_q;
            wlen_d  = 8'd1;
          end else if (is_wordchar(ch_q)) begin
            mode_d    = M_WORD;
            start_d   = pos_q;
            wlen_d    = 8'd1;
            wbuf_d[0] = to_lower(ch_q);
          end else if ((ch_q == CH_LT) || (ch_q == CH_GT)) begin
            mode_d    = M_PEND;
            start_d   = pos_q;
            wlen_d    = 8'd1;
            wbuf_d[0] = ch_q;
          end else if ((ch_q >= CH_LPAREN) && (ch_q <= CH_GT)) begin
            if ((ch_q == CH_MINUS) && !prev_d) begin
              push_d.rec[n[0]] = mk_rec(K_UNARY, '0, '0, pos_q, 8'd1, E_OK, 1'b0);
            end else begin
              push_d.rec[n[0]] = mk_rec(K_OPERATOR, '0, ch_q, pos_q, 8'd1, E_OK, 1'b0);
            end
            n      = n + 2'd1;
            prev_d = 1'b0;
          end else begin
            push_d.rec[n[0]] = mk_rec(K_END, '0, '0, pos_q, '0, E_BAD_CHAR, 1'b1);
            n      = n + 2'd1;
            disc_d = 1'b1;
          end
        end
      end
    end
    push_d.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      wlen_q  <= '0;
      prev_q  <= 1'b0;
      disc_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      wlen_q  <= wlen_d;
      prev_q  <= prev_d;
      disc_q  <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
  end

  assign push_o = push_d;

`ifndef NO_ASSERTIONS
  a_disc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (mode_q == M_IDLE))
    else $error("discarding while a token is open");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && eol_q) |=> (pos_q == '0) && !disc_q && (mode_q == M_IDLE))
    else $error("line terminator did not restart the line");

  a_num_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == M_NUMBER) || (mode_q == M_WORD) || (mode_q == M_PEND)) |-> (wlen_q != '0))
    else $error("open token with zero length");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pos_q) && $stable(mode_q))
    else $error("state moved without an item");
`endif

endmodule

// ----- rtl/bll_outq.sv -----
// Four-entry token record queue: up to two records in, one out per cycle while out_ready_i is high.
module bll_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bll_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bll_pkg::rec_t  rec_o
);
  import bll_pkg::*;

  rec_t                  mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_q, rd_q;
  logic [OUTQ_PTR_W:0]   cnt_q;
  logic                  pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 2));
  assign rec_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OUTQ_PTR_W'(push_i.cnt);
      rd_q  <= rd_q + OUTQ_PTR_W'(pop);
      cnt_q <= cnt_q + (OUTQ_PTR_W+1)'(push_i.cnt) - (OUTQ_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.rec[0];
    if (push_i.cnt == 2'd2) mem_q[wr_q + OUTQ_PTR_W'(1)] <= push_i.rec[1];
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("record pushed without room");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH))
    else $error("queue count out of range");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push_i.cnt == 2'd0) && pop) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count wrong after a pop");
`endif

endmodule

// ----- rtl/basic_line_lexer.sv -----
// Top level of the BASIC line lexer: character input, token record output.
// Usage:
//   Input channel: one character per beat on ch_i, or a line terminator with
//   end_of_line_i set (ch_i ignored). Output channel: one token record per
//   beat; the last record of a line (end or error) has last_of_line_o set.
//   After an error the rest of the line gives no records, and the terminator
//   only starts the next line.
// Path: a record passes the input register, then the lexer step into the
//   record queue, before it is presented on the output; the lexer step
//   waits while the queue has fewer than two free entries.
// Throughput: one character per cycle while the queue has room. A character
//   that closes a token and starts an operator, or a terminator after an
//   open token, gives two records; the output side drains one record per
//   cycle, so a run of such characters is paced by the four-entry queue.
// Reset: line position, token state and queue are cleared; the block is
//   ready to take a character in the first cycle after reset.
// Stall: when out_ready_i is low the queue fills, and input is held off
//   once fewer than two entries are free; nothing is lost or repeated.
module basic_line_lexer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] kind_o,
  output logic [5:0] keyword_index_o,
  output logic [7:0] operator_char_o,
  output logic [7:0] token_start_o,
  output logic [7:0] token_length_o,
  output logic [2:0] error_code_o,
  output logic       last_of_line_o
);
  import bll_pkg::*;

  push_t push;
  logic  room;
  rec_t  rec;

  bll_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .room_i        (room),
    .push_o        (push)
  );

  bll_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec)
  );

  assign kind_o          = rec.kind;
  assign keyword_index_o = rec.kw;
  assign operator_char_o = rec.op;
  assign token_start_o   = rec.start;
  assign token_length_o  = rec.len;
  assign error_code_o    = rec.err;
  assign last_of_line_o  = rec.last;

endmodule
